// ===== design/pps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;
	localparam int TASKS_DEF = 16;
	localparam int TW = 21;
	localparam logic [TW-1:0] TIME_MAX = 21'h1FFFFF;

	typedef enum logic [1:0] {
		ST_SEGMENT = 2'd0,
		ST_ORDER   = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Candidate travelling along the selection chain.
	typedef struct packed {
		logic        valid;
		logic [7:0]  prio;
		logic [15:0] arrival;
		logic [3:0]  id;
		logic [6:0]  slot;
	} cand_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_EMIT,
		S_INSERT,
		S_RESULT
	} state_t;

	// True when candidate a ranks strictly above b (earlier arrival, then lower id, then lower slot breaks priority ties).
	function automatic logic ranks_above(input cand_t a, input cand_t b);
		logic r;
		if (!b.valid) r = a.valid;
		else if (!a.valid) r = 1'b0;
		else if (a.prio != b.prio) r = a.prio > b.prio;
		else if (a.arrival != b.arrival) r = a.arrival < b.arrival;
		else if (a.id != b.id) r = a.id < b.id;
		else r = a.slot < b.slot;
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== design/preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: with nothing running, an accepted item first waits for a chain scan; each
// task it retires costs an emit, a rescan of the chain and a pick of the next task. An
// arrival that is not rejected then inserts, and the final result is released before s_tready returns.
// Throughput: one item at a time; the registered ranking chain and output stalls set it.
// Reset: arst_n clears the table, time, the running task and both result registers.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Event-driven preemptive priority scheduler built on a chain of task cells.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; #(
	parameter int TASKS = TASKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: task_id[3:0], arr_time[19:4], svc_time[35:20],
	// priority_req[43:36], zero fill
	input  wire logic [47:0] s_tdata,
	// tuser: kind
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: seg_task_id[3:0], seg_arrival[19:4], remaining_at_start[35:20],
	// seg_start[56:36], seg_end[77:57], completed[78], status[80:79], zero fill
	output logic [87:0]      m_tdata,
	output logic             m_tlast
);
	localparam int SW = $clog2(TASKS);
	localparam int CW = $clog2(TASKS + 1);

	state_t state_q, state_d;
	logic        kind_q;
	logic [3:0]  in_id_q;
	logic [15:0] in_arr_q, in_svc_q;
	logic [7:0]  in_prio_q;
	logic [TW-1:0] cur_q, seg_q;
	logic [15:0] latest_q;
	logic        run_v_q;
	logic [SW-1:0] run_q;
	logic [CW-1:0] cnt_q;
	logic        out_v_q;
	logic [87:0] out_q;
	logic        out_last_q;
	logic        pend_v_q;
	logic [87:0] pend_q;

	cand_t chain [TASKS+1];
	logic [TASKS-1:0] c_valid;
	logic [15:0] c_rem [TASKS];
	logic [15:0] c_arr [TASKS];
	logic [3:0]  c_id  [TASKS];
	logic [7:0]  c_prio [TASKS];
	logic [TASKS-1:0] wr_en, rem_en, clr_en, skip;
	logic [15:0] rem_value;

	assign chain[0] = '0;

	for (genvar g = 0; g < TASKS; g++) begin : g_cell
		pps_cell #(.SLOT(g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.wr_en(wr_en[g]), .wr_id(in_id_q), .wr_arrival(in_arr_q),
			.wr_remaining(in_svc_q), .wr_prio(in_prio_q),
			.rem_en(rem_en[g]), .rem_value(rem_value), .clr_en(clr_en[g]),
			.skip(skip[g]), .cand_in(chain[g]), .cand_out(chain[g+1]),
			.valid(c_valid[g]), .remaining(c_rem[g]), .arrival(c_arr[g]),
			.id(c_id[g]), .prio(c_prio[g])
		);
		assign skip[g] = run_v_q && (run_q == SW'(g));
	end

	// Finish time of the running task, saturated.
	logic [TW:0] finish_w;
	logic [TW-1:0] finish;
	assign finish_w = {1'b0, seg_q} + (TW+1)'(c_rem[run_q]);
	assign finish = finish_w[TW] ? TIME_MAX : finish_w[TW-1:0];

	logic [TW-1:0] t_w;
	assign t_w = TW'(in_arr_q);

	logic free_any;
	logic [SW-1:0] free_slot;
	always_comb begin
		free_any = 1'b0;
		free_slot = '0;
		for (int i = TASKS - 1; i >= 0; i--) begin
			if (!c_valid[i]) begin
				free_any = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	function automatic logic [87:0] pack(input logic [3:0] id, input logic [15:0] arr,
		input logic [15:0] rem, input logic [TW-1:0] st, input logic [TW-1:0] en,
		input logic done, input status_t stat);
		return {7'd0, stat, done, en, st, rem, arr, id};
	endfunction

	// Each new result waits in a holding register until the next one, or the end of
	// the item, shows whether it is the last of its transaction run.
	logic emit;
	logic [87:0] emit_data;
	logic do_complete, do_preempt, do_insert, do_flush;
	logic reject, room, push_ok, pick;
	logic [TW-1:0] elapsed;
	assign elapsed = cur_q - seg_q;
	assign reject = !kind_q && (in_arr_q < latest_q);
	assign room = !out_v_q || m_tready;
	assign push_ok = !pend_v_q || room;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		emit = 1'b0; emit_data = '0;
		wr_en = '0; rem_en = '0; clr_en = '0; rem_value = '0;
		do_complete = 1'b0; do_preempt = 1'b0; do_insert = 1'b0; do_flush = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// A first scan is needed only when nothing runs.
				if (s_tvalid) state_d = run_v_q ? S_DECIDE : S_SCAN;
			end
			S_SCAN: begin
				if (cnt_q == CW'(TASKS)) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (reject) begin
					if (push_ok) begin
						emit = 1'b1;
						emit_data = pack('0, '0, '0, '0, '0, 1'b0, ST_ORDER);
						state_d = S_RESULT;
					end
				end else if (!run_v_q) begin
					if (chain[TASKS].valid) state_d = S_DECIDE;
					else if (kind_q) state_d = S_RESULT;
					else state_d = S_INSERT;
				end else if (kind_q || finish <= t_w) begin
					if (push_ok) begin
						do_complete = 1'b1;
						emit = 1'b1;
						emit_data = pack(c_id[run_q], c_arr[run_q], c_rem[run_q], seg_q,
							finish, 1'b1, ST_SEGMENT);
						clr_en[run_q] = 1'b1;
						state_d = S_SCAN;
					end
				end else begin
					state_d = S_INSERT;
				end
			end
			S_INSERT: begin
				if (push_ok) begin
					state_d = S_RESULT;
					if (!free_any) begin
						emit = 1'b1;
						emit_data = pack('0, '0, '0, '0, '0, 1'b0, ST_FULL);
					end else begin
						do_insert = 1'b1;
						wr_en[free_slot] = 1'b1;
						if (run_v_q && in_prio_q > c_prio[run_q]) begin
							do_preempt = 1'b1;
							if (elapsed != '0) begin
								emit = 1'b1;
								emit_data = pack(c_id[run_q], c_arr[run_q], c_rem[run_q],
									seg_q, cur_q, 1'b0, ST_SEGMENT);
								rem_en[run_q] = 1'b1;
								rem_value = c_rem[run_q] - elapsed[15:0];
							end
						end
					end
				end
			end
			S_RESULT: begin
				if (!pend_v_q) begin
					state_d = S_IDLE;
				end else if (room) begin
					do_flush = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// When the scan ends without a running task, pick the chain winner.
	assign pick = (state_q == S_DECIDE) && !run_v_q && chain[TASKS].valid && !reject;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q <= '0; seg_q <= '0; latest_q <= '0;
			run_v_q <= 1'b0; run_q <= '0; cnt_q <= '0;
			out_v_q <= 1'b0; out_last_q <= 1'b0; pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && s_tvalid) begin
				cnt_q <= '0;
				if (!s_tuser && s_tdata[19:4] >= latest_q) latest_q <= s_tdata[19:4];
			end
			if (state_q == S_SCAN) cnt_q <= cnt_q + CW'(1);
			if (pick) begin
				run_v_q <= 1'b1;
				run_q <= SW'(chain[TASKS].slot);
				seg_q <= cur_q;
			end
			if (do_complete) begin
				run_v_q <= 1'b0;
				cur_q <= finish;
				cnt_q <= '0;
			end
			if (state_q == S_DECIDE && state_d == S_INSERT && cur_q < t_w) cur_q <= t_w;
			if (do_insert && (!run_v_q || do_preempt)) begin
				run_v_q <= 1'b1;
				run_q <= free_slot;
				seg_q <= cur_q;
			end
			if (emit) begin
				if (pend_v_q) begin
					out_v_q <= 1'b1;
					out_last_q <= 1'b0;
				end else if (m_tvalid && m_tready) begin
					out_v_q <= 1'b0;
				end
				pend_v_q <= 1'b1;
			end else if (do_flush) begin
				out_v_q <= 1'b1;
				out_last_q <= 1'b1;
				pend_v_q <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			kind_q    <= s_tuser;
			in_id_q   <= s_tdata[3:0];
			in_arr_q  <= s_tdata[19:4];
			in_svc_q  <= s_tdata[35:20];
			in_prio_q <= s_tdata[43:36];
		end
		if ((emit && pend_v_q) || do_flush) out_q <= pend_q;
		if (emit) pend_q <= emit_data;
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;
	assign m_tlast  = out_last_q;
endmodule
`default_nettype wire

// ===== design/pps_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_cell
// One task slot: holds its entry and passes the better candidate onward.
// ----------------------------------------------------------------------------
module pps_cell import pps_pkg::*; #(
	parameter int SLOT = 0
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [3:0]  wr_id,
	input  wire logic [15:0] wr_arrival,
	input  wire logic [15:0] wr_remaining,
	input  wire logic [7:0]  wr_prio,
	input  wire logic        rem_en,
	input  wire logic [15:0] rem_value,
	input  wire logic        clr_en,
	input  wire logic        skip,
	input  wire cand_t       cand_in,
	output cand_t            cand_out,
	output logic             valid,
	output logic [15:0]      remaining,
	output logic [15:0]      arrival,
	output logic [3:0]       id,
	output logic [7:0]       prio
);
	logic        valid_q;
	logic [3:0]  id_q;
	logic [15:0] arr_q;
	logic [15:0] rem_q;
	logic [7:0]  prio_q;
	cand_t       mine;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end else if (clr_en) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q   <= wr_id;
			arr_q  <= wr_arrival;
			rem_q  <= wr_remaining;
			prio_q <= wr_prio;
		end else if (rem_en) begin
			rem_q <= rem_value;
		end
	end

	always_comb begin
		mine.valid   = valid_q && !skip;
		mine.prio    = prio_q;
		mine.arrival = arr_q;
		mine.id      = id_q;
		mine.slot    = 7'(SLOT);
	end

	// The chain is registered per cell, so a full pass moves through each slot's register in turn.
	always_ff @(posedge clk) begin
		cand_out <= ranks_above(mine, cand_in) ? mine : cand_in;
	end

	assign valid     = valid_q;
	assign remaining = rem_q;
	assign arrival   = arr_q;
	assign id        = id_q;
	assign prio      = prio_q;
endmodule
`default_nettype wire

// ===== design/pps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the scheduler, attached by bind.
// ----------------------------------------------------------------------------
module pps_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [87:0] m_tdata,
	input wire logic        m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[80:79] != 2'd3)
		else $error("bad status code");
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[80:79] != 2'd0 |-> m_tlast)
		else $error("rejection not final");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted two items back to back");
endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
